>>> src/s3964r_pkg.sv
// types, constants and codes shared by the 3964R frame receiver
// no dependencies; imported by the interfaces, the step logic and the top level
`default_nettype none

package s3964r_pkg;

  // frame length limit and derived counter width
  localparam int unsigned MaxFrame = 512;
  localparam int unsigned CountW   = $clog2(MaxFrame + 1);
  localparam int unsigned TimerW   = 16;

  localparam logic [CountW-1:0] MaxFrameCount = CountW'(MaxFrame);
  localparam logic [TimerW-1:0] TimeoutReset  = TimerW'(220);

  // line characters
  localparam logic [7:0] ChStx = 8'd2;
  localparam logic [7:0] ChEtx = 8'd3;
  localparam logic [7:0] ChDle = 8'd16;
  localparam logic [7:0] ChNak = 8'd21;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_ERROR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_CHECK = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LINE     = 3'd4
  } status_e;

  typedef struct packed {
    phase_e              phase;
    logic                last_dle;
    logic [7:0]          bcc;
    logic [CountW-1:0]   count;
    logic [TimerW-1:0]   timer;
  } state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [2:0] frame_status;
  } result_t;

endpackage

`default_nettype wire

>>> src/s3964r_if.sv
// valid/ready channel interfaces of the 3964R frame receiver
// depends on s3964r_pkg for the timer width
`default_nettype none

interface s3964r_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface s3964r_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [2:0] frame_status;
  modport source (output valid, tx_valid, tx_byte, data_valid, data_byte, frame_end,
                  frame_status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, data_valid, data_byte, frame_end,
                  frame_status, output ready);
endinterface

interface s3964r_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [s3964r_pkg::TimerW-1:0] char_timeout_ticks;
  modport source (output valid, char_timeout_ticks, input ready);
  modport sink   (input valid, char_timeout_ticks, output ready);
endinterface

`default_nettype wire

>>> src/s3964r_step.sv
// next-state and result logic for one received event of the 3964R receiver
// depends on s3964r_pkg
`default_nettype none

module s3964r_step (
  input  s3964r_pkg::state_t                  state_i,
  input  logic [s3964r_pkg::TimerW-1:0]       timeout_i,
  input  logic [1:0]                          action_i,
  input  logic [7:0]                          rx_byte_i,
  output s3964r_pkg::state_t                  state_o,
  output s3964r_pkg::result_t                 result_o
);
  import s3964r_pkg::*;

  logic [TimerW-1:0] timer_inc;
  logic              dle_pair;

  assign timer_inc = (state_i.timer == '1) ? state_i.timer : state_i.timer + TimerW'(1);
  assign dle_pair  = state_i.last_dle && (rx_byte_i == ChDle);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (state_i.phase)
      PH_IDLE: begin
        if (action_i == ACT_BYTE) begin
          if (rx_byte_i == ChStx) begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = ChDle;
            state_o.phase     = PH_FRAME;
            state_o.last_dle  = 1'b0;
            state_o.bcc       = '0;
            state_o.count     = '0;
            state_o.timer     = '0;
          end else if (rx_byte_i != ChNak) begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = ChNak;
          end
        end else if (action_i == ACT_ERROR) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_byte  = ChNak;
        end
      end
      PH_FRAME, PH_CHECK: begin
        case (action_i)
          ACT_TICK: begin
            state_o.timer = timer_inc;
            if (timer_inc >= timeout_i) begin
              result_o.frame_end    = 1'b1;
              result_o.frame_status = ST_TIMEOUT;
              state_o.phase         = PH_IDLE;
              state_o.last_dle      = 1'b0;
            end
          end
          ACT_ERROR: begin
            result_o.frame_end    = 1'b1;
            result_o.frame_status = ST_LINE;
            state_o.phase         = PH_IDLE;
            state_o.last_dle      = 1'b0;
          end
          ACT_BYTE: begin
            state_o.timer = '0;
            if (state_i.phase == PH_CHECK) begin
              // block check byte closes the frame
              result_o.frame_end = 1'b1;
              state_o.phase      = PH_IDLE;
              state_o.last_dle   = 1'b0;
              if (rx_byte_i == state_i.bcc) begin
                result_o.tx_valid     = 1'b1;
                result_o.tx_byte      = ChDle;
                result_o.frame_status = ST_OK;
              end else begin
                result_o.frame_status = ST_MISMATCH;
              end
            end else begin
              state_o.bcc = state_i.bcc ^ rx_byte_i;
              if (dle_pair) begin
                // stuffed dle dropped
                state_o.last_dle = 1'b0;
              end else if (state_i.count >= MaxFrameCount) begin
                result_o.frame_end    = 1'b1;
                result_o.frame_status = ST_OVERFLOW;
                state_o.phase         = PH_IDLE;
                state_o.last_dle      = 1'b0;
              end else begin
                state_o.count       = state_i.count + CountW'(1);
                result_o.data_valid = 1'b1;
                result_o.data_byte  = rx_byte_i;
                if (state_i.last_dle && (rx_byte_i == ChEtx)) begin
                  state_o.phase    = PH_CHECK;
                  state_o.last_dle = 1'b0;
                end else begin
                  state_o.last_dle = (rx_byte_i == ChDle);
                end
              end
            end
          end
          default: begin
            state_o = state_i;
          end
        endcase
      end
      default: begin
        state_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/serial_3964r_frame_receiver.sv
// top level of the 3964R frame receiver: input register, step logic, result register
// depends on s3964r_pkg, s3964r_if.sv and s3964r_step
// an accepted request waits in the input register, passes s3964r_step and shows on out_o from the result register
// throughput: one request per cycle while out_o does not stall, as the state update in s3964r_step is combinational
// reset: phase idle, block check, count and timer zero, char_timeout_ticks 220, no result
`default_nettype none

module serial_3964r_frame_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  s3964r_in_if.sink           in_i,
  s3964r_cfg_if.sink          cfg_i,
  s3964r_out_if.source        out_o
);
  import s3964r_pkg::*;

  // input register stage
  logic              in_v_q;
  logic [1:0]        act_q;
  logic [7:0]        byte_q;

  // protocol state and timeout register
  state_t            st_q, st_d;
  logic [TimerW-1:0] timeout_q;

  // result register stage
  logic              out_v_q;
  result_t           out_q, res_d;

  logic              advance;

  // the result register frees whenever it is empty or being drained
  assign advance     = !out_v_q || out_o.ready;
  // input register takes a new request while it is empty or its content moves forward
  assign in_i.ready  = !in_v_q || advance;
  assign cfg_i.ready = 1'b1;

  s3964r_step u_step (
    .state_i   (st_q),
    .timeout_i (timeout_q),
    .action_i  (act_q),
    .rx_byte_i (byte_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      act_q  <= in_i.action;
      byte_q <= in_i.rx_byte;
    end
  end

  // protocol state advances when the held request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, last_dle: 1'b0, bcc: '0, count: '0, timer: '0};
    end else if (in_v_q && advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.char_timeout_ticks;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q && advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.tx_valid     = out_q.tx_valid;
  assign out_o.tx_byte      = out_q.tx_byte;
  assign out_o.data_valid   = out_q.data_valid;
  assign out_o.data_byte    = out_q.data_byte;
  assign out_o.frame_end    = out_q.frame_end;
  assign out_o.frame_status = out_q.frame_status;

  // a delivered data byte never coincides with the end of a frame
  a_data_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.data_valid |-> !out_q.frame_end)
    else $error("data byte delivered together with frame end");

  // an acknowledge at frame end is only sent for a good block check
  a_ack_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.frame_end && out_q.tx_valid |-> out_q.frame_status == ST_OK)
    else $error("frame end acknowledged with bad status");

  // any processed request that ends a frame leaves the link idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && advance && res_d.frame_end |=> st_q.phase == PH_IDLE)
    else $error("frame end did not return to idle");

  // the dle flag is cleared whenever the link is idle
  a_idle_dle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_IDLE |-> !st_q.last_dle)
    else $error("dle flag left set while idle");

  // stored byte count never passes the frame limit
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.count <= MaxFrameCount)
    else $error("stored count beyond frame limit");

endmodule

`default_nettype wire

>>> dv/tb_serial_3964r_frame_receiver.sv
// self-checking testbench for the 3964R frame receiver: directed and random line traffic
// depends on s3964r_pkg, the channel interfaces in s3964r_if.sv and serial_3964r_frame_receiver
`timescale 1ns / 1ps

module tb_serial_3964r_frame_receiver;
  import s3964r_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  // action code with no meaning, the block must ignore it
  localparam logic [1:0] ActUnused = 2'd3;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CHECK,
    FRAME_LINE_CUT,
    FRAME_SILENT_CUT
  } frame_fault_e;

  // predicts the receiver's answer to every accepted request and checks the responses in order
  class frame_rx_scoreboard;
    phase_e      phase;
    bit          last_dle;
    logic [7:0]  bcc;
    int unsigned stored;
    int unsigned silence;
    int unsigned timeout;
    result_t     expected_q[$];
    int unsigned mismatch_count;

    function new();
      phase          = PH_IDLE;
      last_dle       = 1'b0;
      bcc            = '0;
      stored         = 0;
      silence        = 0;
      timeout        = TimeoutReset;
      mismatch_count = 0;
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
    endtask

    function void end_frame(inout result_t r, input status_e st);
      r.frame_end    = 1'b1;
      r.frame_status = st;
      phase          = PH_IDLE;
      last_dle       = 1'b0;
    endfunction

    // one line event in, one expected response out
    function void note_event(logic [1:0] act, logic [7:0] b);
      result_t r;
      r = '0;
      if (phase == PH_IDLE) begin
        if (act == ACT_BYTE) begin
          if (b == ChStx) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = ChDle;
            phase      = PH_FRAME;
            last_dle   = 1'b0;
            bcc        = '0;
            stored     = 0;
            silence    = 0;
          end else if (b != ChNak) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = ChNak;
          end
        end else if (act == ACT_ERROR) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = ChNak;
        end
      end else if (act == ACT_TICK) begin
        if (silence < 65535) silence++;
        if (silence >= timeout) end_frame(r, ST_TIMEOUT);
      end else if (act == ACT_ERROR) begin
        end_frame(r, ST_LINE);
      end else if (act == ACT_BYTE) begin
        silence = 0;
        if (phase == PH_CHECK) begin
          if (b == bcc) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = ChDle;
            end_frame(r, ST_OK);
          end else begin
            end_frame(r, ST_MISMATCH);
          end
        end else begin
          bcc = bcc ^ b;
          if (last_dle && b == ChDle) begin
            last_dle = 1'b0;
          end else if (stored >= MaxFrame) begin
            end_frame(r, ST_OVERFLOW);
          end else begin
            stored++;
            r.data_valid = 1'b1;
            r.data_byte  = b;
            if (last_dle && b == ChEtx) begin
              phase    = PH_CHECK;
              last_dle = 1'b0;
            end else begin
              last_dle = (b == ChDle);
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    task check_response(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("response with nothing pending: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid got %0h want %0h", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %0h want %0h", got.tx_byte, want.tx_byte));
      if (got.data_valid !== want.data_valid)
        report($sformatf("data_valid got %0h want %0h", got.data_valid, want.data_valid));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte got %0h want %0h", got.data_byte, want.data_byte));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end got %0h want %0h", got.frame_end, want.frame_end));
      if (got.frame_status !== want.frame_status)
        report($sformatf("frame_status got %0h want %0h", got.frame_status,
                         want.frame_status));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  s3964r_in_if  req_if ();
  s3964r_cfg_if cfg_if ();
  s3964r_out_if rsp_if ();

  serial_3964r_frame_receiver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .cfg_i  (cfg_if),
    .out_o  (rsp_if)
  );

  frame_rx_scoreboard sb;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;

  // idle pattern state: steady stretches have no gaps and start no new stalls
  bit          steady = 1'b0;
  int unsigned steady_left = 0;
  int unsigned stall_left = 0;

  always #1 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // line byte biased toward the control characters
  function automatic logic [7:0] pick_line_byte();
    case ($urandom_range(0, 9))
      0: return ChDle;
      1: return ChEtx;
      2: return ChStx;
      3: return ChNak;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver-side backpressure, plus the switch between steady and bursty stretches
  always @(posedge clk_i) begin
    if (steady_left == 0) begin
      steady      <= ($urandom_range(0, 3) == 0);
      steady_left <= $urandom_range(50, 400);
    end else begin
      steady_left <= steady_left - 1;
    end
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // every accepted response is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response({rsp_if.tx_valid, rsp_if.tx_byte, rsp_if.data_valid,
                         rsp_if.data_byte, rsp_if.frame_end, rsp_if.frame_status});
  end

  // watchdog for a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("serial_3964r_frame_receiver: mismatch");
      $finish;
    end
  end

  // one request; valid stays high on return so back-to-back requests need no gap
  task automatic send_event(logic [1:0] act, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.rx_byte <= b;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_event(act, b);
    sent_count++;
  endtask

  task automatic idle_input();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // timeout register only changes with no request in flight
  task automatic write_timeout(logic [15:0] ticks);
    idle_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_if.valid              <= 1'b1;
    cfg_if.char_timeout_ticks <= ticks;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.timeout   = ticks;
    cfg_if.valid <= 1'b0;
  endtask

  // ticks between characters, kept below the timeout; sometimes right at the edge of it
  task automatic maybe_ticks();
    int unsigned cap;
    int unsigned n;
    if (sb.timeout < 2 || $urandom_range(0, 3) != 0) return;
    cap = sb.timeout - 1;
    if (cap <= 64 && $urandom_range(0, 7) == 0) n = cap;
    else n = $urandom_range(1, (cap < 4) ? cap : 4);
    repeat (n) send_event(ACT_TICK, 8'($urandom));
  endtask

  // STX, n_data stored bytes with DLE doubled, DLE ETX, check byte; faults cut or spoil it
  task automatic send_frame(int unsigned n_data, frame_fault_e fault);
    logic [7:0] seq[$];
    logic [7:0] b;
    int         i;
    int         cut_at;
    int unsigned ticks;
    for (i = 0; i < n_data; i++) begin
      b = pick_line_byte();
      seq.push_back(b);
      if (b == ChDle) seq.push_back(ChDle);
    end
    seq.push_back(ChDle);
    seq.push_back(ChEtx);
    // cutting at the end of the sequence hits the wait for the check byte
    if (fault == FRAME_LINE_CUT || fault == FRAME_SILENT_CUT)
      cut_at = $urandom_range(0, seq.size());
    else
      cut_at = seq.size() + 1;
    send_event(ACT_BYTE, ChStx);
    for (i = 0; i <= seq.size(); i++) begin
      if (i == cut_at) begin
        if (fault == FRAME_LINE_CUT) begin
          send_event(ACT_ERROR, 8'($urandom));
        end else begin
          ticks = (sb.timeout == 0) ? 1 : sb.timeout;
          repeat (ticks) send_event(ACT_TICK, 8'($urandom));
        end
        return;
      end
      if (i == seq.size()) break;
      maybe_ticks();
      send_event(ACT_BYTE, seq[i]);
    end
    maybe_ticks();
    b = sb.bcc;
    if (fault == FRAME_BAD_CHECK) b = b ^ 8'($urandom_range(1, 255));
    send_event(ACT_BYTE, b);
  endtask

  // unstructured traffic, then a line error to force the receiver back to idle
  task automatic send_noise(int unsigned n);
    repeat (n) send_event(2'($urandom_range(0, 3)), pick_line_byte());
    send_event(ACT_ERROR, 8'($urandom));
  endtask

  task automatic random_episode();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    if (r < 62) send_frame(n, FRAME_GOOD);
    else if (r < 74) send_frame(n, FRAME_BAD_CHECK);
    else if (r < 84) send_frame(n, FRAME_LINE_CUT);
    // a timeout cut costs as many ticks as the register holds, so only for short ones
    else if (r < 92) send_frame(n, (sb.timeout <= 64) ? FRAME_SILENT_CUT : FRAME_LINE_CUT);
    else send_noise($urandom_range(3, 15));
  endtask

  initial begin
    logic [15:0] settings[6];
    int unsigned phase_end;
    int          p;

    rst_ni                    = 1'b0;
    req_if.valid              = 1'b0;
    req_if.action             = ACT_BYTE;
    req_if.rx_byte            = '0;
    cfg_if.valid              = 1'b0;
    cfg_if.char_timeout_ticks = '0;
    rsp_if.ready              = 1'b0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle: NAK and ticks ignored, unused action ignored, error and stray bytes get NAK
    send_event(ACT_BYTE, ChNak);
    send_event(ACT_TICK, 8'h00);
    send_event(ActUnused, 8'hFF);
    send_event(ACT_ERROR, 8'h00);
    send_event(ACT_BYTE, 8'hFF);
    send_event(ACT_BYTE, 8'h00);

    // good frame: doubled DLE, STX as data, lone DLE before data, ignored events inside
    send_event(ACT_BYTE, ChStx);
    send_event(ACT_BYTE, 8'hFF);
    send_event(ACT_BYTE, ChDle);
    send_event(ACT_BYTE, ChDle);
    send_event(ACT_BYTE, 8'h00);
    send_event(ACT_BYTE, ChStx);
    send_event(ACT_BYTE, ChDle);
    send_event(ACT_BYTE, 8'h41);
    send_event(ActUnused, 8'h00);
    send_event(ACT_TICK, 8'hFF);
    send_event(ACT_BYTE, ChDle);
    send_event(ACT_BYTE, ChEtx);
    send_event(ACT_BYTE, sb.bcc);

    // wrong check byte ends the frame silently
    send_event(ACT_BYTE, ChStx);
    send_event(ACT_BYTE, 8'h55);
    send_event(ACT_BYTE, ChDle);
    send_event(ACT_BYTE, ChEtx);
    send_event(ACT_BYTE, sb.bcc ^ 8'h80);

    // line error inside a frame: no NAK, just the status
    send_event(ACT_BYTE, ChStx);
    send_event(ACT_ERROR, 8'h00);

    // zero timeout register: first tick in a frame ends it
    write_timeout(16'd0);
    send_event(ACT_BYTE, ChStx);
    send_event(ACT_TICK, 8'h00);

    // random phases over several timeout settings, extremes included
    settings[0] = 16'hFFFF;
    settings[1] = 16'd3;
    settings[2] = 16'd0;
    settings[3] = 16'd1;
    settings[4] = 16'd64;
    settings[5] = 16'($urandom_range(2, 64));
    for (p = 0; p < 6; p++) begin
      write_timeout(settings[p]);
      if (p == 0) begin
        // one full frame: the closing DLE fills the buffer, the ETX overflows it
        send_frame(MaxFrame - 1, FRAME_GOOD);
        send_event(ACT_ERROR, 8'($urandom));
      end
      phase_end = sent_count + 120;
      while (sent_count < phase_end) random_episode();
    end

    // drain: everything predicted must come back, then a short settle
    idle_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("serial_3964r_frame_receiver: match");
    end else begin
      $display("serial_3964r_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

>>> serial_3964r_frame_receiver.f
src/s3964r_pkg.sv
src/s3964r_if.sv
src/s3964r_step.sv
src/serial_3964r_frame_receiver.sv
dv/tb_serial_3964r_frame_receiver.sv
